### src/wpp_pkg.sv
// Package for the windowed peak-to-peak meter: field widths, register reset
// value and the result record passed between the tracker and the output stage.
// No dependencies.
package wpp_pkg;

    localparam int SAMPLE_BITS = 14;
    localparam int TIME_BITS   = 32;
    localparam int WIN_BITS    = 32;
    localparam int CMP_BITS    = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(100);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] current_span;
        logic [SAMPLE_BITS-1:0] last_span;
        logic                   window_closed;
    } t_result;

endpackage

### src/wpp_tracker.sv
// Window state and per-sample update: elapsed-time compare, running max/min,
// span of the open and the last closed window.
// Depends on wpp_pkg.
module wpp_tracker import wpp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample_code,
    input  logic [TIME_BITS-1:0]   i_timestamp,
    input  logic [WIN_BITS-1:0]    i_window_length,
    output t_result                o_result
);

    logic [TIME_BITS-1:0]   r_window_start, n_window_start;
    logic [SAMPLE_BITS-1:0] r_running_max,  n_running_max;
    logic [SAMPLE_BITS-1:0] r_running_min,  n_running_min;
    logic                   r_have_sample,  n_have_sample;
    logic [SAMPLE_BITS-1:0] r_closed_span,  n_closed_span;

    logic [TIME_BITS-1:0]   elapsed;
    logic                   closed;

    // wrapping difference, modulo 2^TIME_BITS
    assign elapsed = i_timestamp - r_window_start;
    assign closed  = CMP_BITS'(elapsed) >= CMP_BITS'(i_window_length);

    always_comb begin
        n_window_start = r_window_start;
        n_running_max  = r_running_max;
        n_running_min  = r_running_min;
        n_have_sample  = 1'b1;
        n_closed_span  = r_closed_span;
        if (closed) begin
            n_closed_span  = r_have_sample ? (r_running_max - r_running_min) : '0;
            n_window_start = i_timestamp;
            n_running_max  = i_sample_code;
            n_running_min  = i_sample_code;
        end else if (!r_have_sample) begin
            n_running_max  = i_sample_code;
            n_running_min  = i_sample_code;
        end else begin
            if (i_sample_code > r_running_max) begin
                n_running_max = i_sample_code;
            end
            if (i_sample_code < r_running_min) begin
                n_running_min = i_sample_code;
            end
        end
    end

    // window always holds this sample after the update
    always_comb begin
        o_result.current_span  = n_running_max - n_running_min;
        o_result.last_span     = n_closed_span;
        o_result.window_closed = closed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_running_max  <= '0;
            r_running_min  <= '0;
            r_have_sample  <= 1'b0;
            r_closed_span  <= '0;
        end else if (i_en) begin
            r_window_start <= n_window_start;
            r_running_max  <= n_running_max;
            r_running_min  <= n_running_min;
            r_have_sample  <= n_have_sample;
            r_closed_span  <= n_closed_span;
        end
    end

endmodule

### src/wpp_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on wpp_pkg.
module wpp_out_reg import wpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### src/windowed_peak_to_peak_meter.sv
// Top level of the windowed peak-to-peak meter: input register, window length
// register, tracker and result register. Depends on wpp_pkg, wpp_tracker, wpp_out_reg.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_ready          i_sample_code, i_timestamp
//  result    out        o_valid / i_ready          o_current_span, o_last_span,
//                                                  o_window_closed
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (window length)
//
// One sample per cycle sustained while results are taken; o_valid rises once the input
// transaction has passed the input register, then the result register fed by one
// compare and min/max update. Synchronous active-low reset sets window length to 100
// and clears window state. A stalled result holds both stages; the input register
// refills in the cycle the result is taken. Config is always ready; zero is ignored.
module windowed_peak_to_peak_meter import wpp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_code,
    input  logic [TIME_BITS-1:0]   i_timestamp,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_current_span,
    output logic [SAMPLE_BITS-1:0] o_last_span,
    output logic                   o_window_closed,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [WIN_BITS-1:0]    i_cfg_data
);

    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic [TIME_BITS-1:0]   r_s1_time;
    logic [WIN_BITS-1:0]    r_window_length;

    logic    can_load;
    logic    s1_adv;
    logic    in_fire;
    t_result trk_result;
    t_result out_result;

    assign s1_adv      = r_s1_valid && can_load;
    assign o_ready     = !r_s1_valid || can_load;
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sample <= i_sample_code;
            r_s1_time   <= i_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_data != '0)) begin
            r_window_length <= i_cfg_data;
        end
    end

    wpp_tracker u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (s1_adv),
        .i_sample_code   (r_s1_sample),
        .i_timestamp     (r_s1_time),
        .i_window_length (r_window_length),
        .o_result        (trk_result)
    );

    wpp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv),
        .i_result   (trk_result),
        .i_ready    (i_ready),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_current_span  = out_result.current_span;
    assign o_last_span     = out_result.last_span;
    assign o_window_closed = out_result.window_closed;

    // a fresh window holds only the sample that opened it
    a_closed_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_window_closed |-> o_current_span == '0)
        else $error("closing result has nonzero current span");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_length != '0)
        else $error("window length is zero");

    a_zero_write_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && (i_cfg_data == '0) |=> $stable(r_window_length))
        else $error("zero write changed window length");

    // a result held under stall keeps the input stage from advancing
    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && o_valid && !i_ready |=> r_s1_valid && $stable(r_s1_time))
        else $error("input stage advanced during output stall");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_peak_to_peak_meter: directed corner samples, then
// random sample streams under a range of window lengths and handshake pressure.
// Depends on wpp_pkg and the meter RTL.
module tb_top;
    import wpp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 115;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_MAX    = 10;
    localparam logic [SAMPLE_BITS-1:0] CODE_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] code;
        logic [TIME_BITS-1:0]   ts;
    } t_sample;

    typedef struct packed {
        logic [WIN_BITS-1:0]    win_len;
        logic [TIME_BITS-1:0]   start;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] lo;
        logic                   seen;
        logic [SAMPLE_BITS-1:0] last_span;
    } t_meter;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample_code = '0;
    logic [TIME_BITS-1:0]   i_timestamp = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] o_current_span;
    logic [SAMPLE_BITS-1:0] o_last_span;
    logic                   o_window_closed;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [WIN_BITS-1:0]    i_cfg_data = '0;

    t_sample             sample_q[$];
    logic [WIN_BITS-1:0] winlen_q[$];
    t_result             expected_spans[$];

    // meter_now follows accepted transactions; meter_plan runs ahead with the
    // stimulus so timestamps can be aimed at window edges
    t_meter              meter_now;
    t_meter              meter_plan;
    logic [TIME_BITS-1:0] last_ts = '0;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int src_idle_tbl[4]  = '{0, 57, 0, 8};
    int snk_stall_tbl[4] = '{0, 0, 57, 8};

    int n_queued     = 0;
    int n_accepted   = 0;
    int n_cfg_queued = 0;
    int n_cfg_done   = 0;
    int n_checked    = 0;
    int n_closes     = 0;
    int n_bad        = 0;
    int n_cycles     = 0;

    logic [WIN_BITS-1:0] win_plan[RANDOM_PHASES] = '{
        32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'd100, 32'd2,
        32'd1000, 32'h8000_0000, 32'd16, 32'd50, 32'd1, 32'd3
    };

    windowed_peak_to_peak_meter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_code   (i_sample_code),
        .i_timestamp     (i_timestamp),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_current_span  (o_current_span),
        .o_last_span     (o_last_span),
        .o_window_closed (o_window_closed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_meter meter_cleared();
        t_meter m;
        m = '0;
        m.win_len = WIN_RESET;
        return m;
    endfunction

    // Advance one window tracker by one sample and return the spans it reports
    function automatic t_result meter_advance(inout t_meter m,
                                              input logic [SAMPLE_BITS-1:0] code,
                                              input logic [TIME_BITS-1:0] ts);
        logic [TIME_BITS-1:0] elapsed;
        t_result r;
        elapsed = ts - m.start;   // wraps, so a backwards step reads as a long wait
        r.window_closed = CMP_BITS'(elapsed) >= CMP_BITS'(m.win_len);
        if (r.window_closed) begin
            m.last_span = m.seen ? SAMPLE_BITS'(m.hi - m.lo) : '0;
            m.start = ts;
            m.hi = code;
            m.lo = code;
            m.seen = 1'b1;
        end else if (!m.seen) begin
            m.hi = code;
            m.lo = code;
            m.seen = 1'b1;
        end else begin
            if (code > m.hi) m.hi = code;
            if (code < m.lo) m.lo = code;
        end
        r.current_span = m.seen ? SAMPLE_BITS'(m.hi - m.lo) : '0;
        r.last_span = m.last_span;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_code();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 20) return CODE_MAX;
        return SAMPLE_BITS'($urandom);
    endfunction

    // Mostly timestamps near the open window's edges or drifting on, some noise
    function automatic logic [TIME_BITS-1:0] aim_timestamp();
        int unsigned pick;
        logic [TIME_BITS-1:0] hop;
        pick = $urandom_range(0, 99);
        hop = TIME_BITS'(meter_plan.win_len >> 3) + 1'b1;
        if (pick < 15) return meter_plan.start + meter_plan.win_len;
        if (pick < 30) return meter_plan.start + meter_plan.win_len - 1'b1;
        if (pick < 70) return last_ts + $urandom_range(0, hop);
        if (pick < 85) return meter_plan.start + $urandom_range(0, meter_plan.win_len - 1'b1);
        if (pick < 95) return $urandom;
        return meter_plan.start - 1'b1;
    endfunction

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] code,
                                input logic [TIME_BITS-1:0] ts);
        t_sample s;
        s.code = code;
        s.ts = ts;
        void'(meter_advance(meter_plan, code, ts));
        last_ts = ts;
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_spans.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_BITS-1:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        winlen_q.push_back(value);
        n_cfg_queued++;
        if (value != '0) meter_plan.win_len = value;
        while (n_cfg_done != n_cfg_queued) @(posedge i_clk);
    endtask

    // Driver: next sample goes out once the current one is taken (or none is up)
    always @(posedge i_clk) begin : drive
        t_sample s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (!i_valid || o_ready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s = sample_q.pop_front();
                    i_valid <= 1'b1;
                    i_sample_code <= s.code;
                    i_timestamp <= s.ts;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (winlen_q.size() != 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_data <= winlen_q.pop_front();
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Monitor: predicts on each input transaction, checks each result transaction
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data != '0) meter_now.win_len = i_cfg_data;
                n_cfg_done++;
            end
            if (i_valid && o_ready) begin
                expected_spans.push_back(meter_advance(meter_now, i_sample_code, i_timestamp));
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                got.current_span = o_current_span;
                got.last_span = o_last_span;
                got.window_closed = o_window_closed;
                if (expected_spans.size() == 0) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX)
                        $display("unexpected result: span %0d last %0d closed %0b",
                                 got.current_span, got.last_span, got.window_closed);
                end else begin
                    want = expected_spans.pop_front();
                    n_checked++;
                    n_closes += want.window_closed;
                    if (got.current_span !== want.current_span ||
                        got.last_span !== want.last_span ||
                        got.window_closed !== want.window_closed) begin
                        n_bad++;
                        if (n_bad <= REPORT_MAX)
                            $display("mismatch #%0d: expected span %0d last %0d closed %0b, got span %0d last %0d closed %0b",
                                     n_checked, want.current_span, want.last_span,
                                     want.window_closed, got.current_span,
                                     got.last_span, got.window_closed);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d samples checked",
                     n_cycles, n_checked, n_queued);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        meter_now = meter_cleared();
        meter_plan = meter_cleared();
        win_plan[9] = $urandom_range(2, 300);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the very first sample closes an empty window (span 0), then
        // extremes, exact window edge, backwards time and wrap past 2^32.
        queue_sample(14'h1234, 32'd200);
        queue_sample(CODE_MAX, 32'd201);
        queue_sample('0, 32'd250);
        queue_sample(14'h2AAA, 32'd299);
        queue_sample(14'h1555, 32'd300);
        queue_sample(CODE_MAX, 32'd300);
        queue_sample('0, 32'd100);
        queue_sample(14'h2AAA, 32'hFFFF_FFFF);
        queue_sample(14'h1555, 32'h0000_0000);
        queue_sample(CODE_MAX, 32'd98);
        queue_sample('0, 32'd99);
        queue_sample(14'h0001, 32'd100);
        queue_sample(14'h3FFE, 32'h7FFF_FFFF);
        queue_sample(14'h2000, 32'h8000_0000);
        queue_sample(14'h1FFF, 32'hFFFF_FFFE);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_window(win_plan[ph]);
            src_idle_pct = src_idle_tbl[ph % 4];
            snk_stall_pct = snk_stall_tbl[ph % 4];
            for (int k = 0; k < PHASE_ITEMS; k++) queue_sample(pick_code(), aim_timestamp());
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d samples (%0d closed a window) across %0d window length writes",
                 n_checked, n_closes, n_cfg_done);
        $display("lengths ranged from 1 to 2^32-1 with a zero write, under four pressure mixes");
        if (n_bad == 0 && expected_spans.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("status: fail");
        end
        $finish;
    end

endmodule

### windowed_peak_to_peak_meter.f
src/wpp_pkg.sv
src/wpp_tracker.sv
src/wpp_out_reg.sv
src/windowed_peak_to_peak_meter.sv
bench/tb_top.sv
